// ----- hdl/lpr_pkg.sv -----
// shared types and constants for the lru page replacement unit
`timescale 1ns / 1ps
`default_nettype none
package lpr_pkg;

  localparam int MAX_FRAMES = 16;
  localparam int FRAME_BITS = 4;
  localparam int FILL_BITS  = 5;
  localparam int PAGE_BITS  = 16;
  localparam int COUNT_BITS = 16;
  localparam int CFG_BITS   = 5;

  localparam logic [FRAME_BITS-1:0] RANK_MAX  = FRAME_BITS'(MAX_FRAMES - 1);
  localparam logic [CFG_BITS-1:0]   CFG_RESET = CFG_BITS'(MAX_FRAMES);

  typedef struct packed {
    logic [PAGE_BITS-1:0] page;
    logic                 end_of_string;
  } lpr_in_t;

  typedef struct packed {
    logic                  hit;
    logic [FRAME_BITS-1:0] frame;
    logic                  evicted_valid;
    logic [PAGE_BITS-1:0]  evicted_page;
    logic [COUNT_BITS-1:0] hit_total;
    logic [COUNT_BITS-1:0] miss_total;
  } lpr_out_t;

  typedef struct packed {
    logic capture;
    logic commit;
  } lpr_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } lpr_state_t;

endpackage
`default_nettype wire

// ----- hdl/lru_page_replacement_unit.sv -----
// lru page replacement unit top level
// a request is taken when start is high and busy is low; busy then stays high for one cycle
// the frame search and victim select run in the request cycle, ranks and frames update the next
// the result strobe and result register load at the edge that ends the update state
// a new request waits until busy is low; the receiver cannot stall; synchronous active-low reset clears
// fill count, totals and control, and sets frames_in_use to 16; no clearing pass is needed
`timescale 1ns / 1ps
`default_nettype none
module lru_page_replacement_unit (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire lpr_pkg::lpr_in_t             in_req,
  output logic                              out_valid,
  output lpr_pkg::lpr_out_t                 out_res,
  input  wire logic                         cfg_we,
  input  wire logic [lpr_pkg::CFG_BITS-1:0] cfg_wdata
);

  lpr_pkg::lpr_cmd_t cmd;

  lpr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  lpr_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

// ----- hdl/lpr_ctrl.sv -----
// control state machine: lookup on request, commit in the update state that follows
`timescale 1ns / 1ps
`default_nettype none
module lpr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  output lpr_pkg::lpr_cmd_t  cmd
);

  lpr_pkg::lpr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lpr_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lpr_pkg::ST_IDLE: begin
        if (start) state_nxt = lpr_pkg::ST_UPDATE;
      end
      lpr_pkg::ST_UPDATE: begin
        state_nxt = lpr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = lpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    case (state_r)
      lpr_pkg::ST_IDLE: begin
        cmd.capture = start;
      end
      lpr_pkg::ST_UPDATE: begin
        busy       = 1'b1;
        cmd.commit = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/lpr_datapath.sv -----
// frame table, recency ranks, search and victim select, totals and result register
`timescale 1ns / 1ps
`default_nettype none
module lpr_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire lpr_pkg::lpr_cmd_t            cmd,
  input  wire lpr_pkg::lpr_in_t             in_req,
  input  wire logic                         cfg_we,
  input  wire logic [lpr_pkg::CFG_BITS-1:0] cfg_wdata,
  output logic                              out_valid,
  output lpr_pkg::lpr_out_t                 out_res
);

  localparam int NF = lpr_pkg::MAX_FRAMES;
  localparam int FB = lpr_pkg::FRAME_BITS;
  localparam int LB = lpr_pkg::FILL_BITS;
  localparam int PB = lpr_pkg::PAGE_BITS;
  localparam int CB = lpr_pkg::COUNT_BITS;
  localparam int LV = $clog2(NF);

  logic [lpr_pkg::CFG_BITS-1:0] cfg_frames_r;
  logic [PB-1:0]                frame_page_r [NF];
  logic [FB-1:0]                rank_r [NF];
  logic [FB-1:0]                rank_nxt [NF];
  logic [LB-1:0]                filled_r, filled_nxt;
  logic [CB-1:0]                hits_r, hits_nxt;
  logic [CB-1:0]                misses_r, misses_nxt;

  // captured lookup
  logic [PB-1:0] page_r;
  logic          eos_r;
  logic          hit_r;
  logic          fill_r;
  logic [FB-1:0] sel_r;
  logic [PB-1:0] ev_page_r;
  logic [FB-1:0] limit_r;
  logic [NF-1:0] act_r;

  logic          out_valid_r;
  lpr_pkg::lpr_out_t out_res_r;

  // lookup logic
  logic [LB-1:0] m_eff;
  logic [LB-1:0] active;
  logic [NF-1:0] act;
  logic [NF-1:0] match;
  logic          hit;
  logic [FB-1:0] hit_idx;
  logic          fill;
  logic [FB-1:0] victim;
  logic [FB-1:0] sel;
  logic          tv [LV+1][NF];
  logic [FB-1:0] tr [LV+1][NF];
  logic [FB-1:0] ti [LV+1][NF];

  always_comb begin
    if (cfg_frames_r == '0) begin
      m_eff = LB'(1);
    end else if (LB'(cfg_frames_r) > LB'(NF)) begin
      m_eff = LB'(NF);
    end else begin
      m_eff = LB'(cfg_frames_r);
    end
    active = (filled_r < m_eff) ? filled_r : m_eff;
  end

  always_comb begin
    for (int i = 0; i < NF; i++) begin
      act[i]   = LB'(i) < active;
      match[i] = act[i] && (frame_page_r[i] == in_req.page);
    end
    hit     = |match;
    hit_idx = '0;
    for (int i = NF - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = FB'(i);
    end
  end

  // oldest active frame, ties to the lower index
  always_comb begin
    for (int l = 0; l <= LV; l++) begin
      for (int j = 0; j < NF; j++) begin
        tv[l][j] = 1'b0;
        tr[l][j] = '0;
        ti[l][j] = '0;
      end
    end
    for (int j = 0; j < NF; j++) begin
      tv[0][j] = act[j];
      tr[0][j] = rank_r[j];
      ti[0][j] = FB'(j);
    end
    for (int l = 0; l < LV; l++) begin
      for (int j = 0; j < (NF >> (l + 1)); j++) begin
        if (tv[l][2*j+1] && (!tv[l][2*j] || (tr[l][2*j+1] > tr[l][2*j]))) begin
          tv[l+1][j] = 1'b1;
          tr[l+1][j] = tr[l][2*j+1];
          ti[l+1][j] = ti[l][2*j+1];
        end else begin
          tv[l+1][j] = tv[l][2*j];
          tr[l+1][j] = tr[l][2*j];
          ti[l+1][j] = ti[l][2*j];
        end
      end
    end
    victim = tv[LV][0] ? ti[LV][0] : '0;
  end

  always_comb begin
    fill = !hit && (filled_r < m_eff);
    if (hit) begin
      sel = hit_idx;
    end else if (fill) begin
      sel = filled_r[FB-1:0];
    end else begin
      sel = victim;
    end
  end

  // commit logic
  always_comb begin
    for (int i = 0; i < NF; i++) begin
      rank_nxt[i] = rank_r[i];
      if (act_r[i] && (!hit_r || (rank_r[i] < limit_r)) && (rank_r[i] != lpr_pkg::RANK_MAX)) begin
        rank_nxt[i] = rank_r[i] + FB'(1);
      end
      if (FB'(i) == sel_r) rank_nxt[i] = '0;
    end
  end

  logic [CB-1:0] hit_cnt, miss_cnt;

  always_comb begin
    hit_cnt  = hits_r;
    miss_cnt = misses_r;
    if (hit_r) begin
      if (hits_r != '1) hit_cnt = hits_r + CB'(1);
    end else begin
      if (misses_r != '1) miss_cnt = misses_r + CB'(1);
    end
    filled_nxt = fill_r ? filled_r + LB'(1) : filled_r;
    hits_nxt   = hit_cnt;
    misses_nxt = miss_cnt;
    if (eos_r) begin
      filled_nxt = '0;
      hits_nxt   = '0;
      misses_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_frames_r <= lpr_pkg::CFG_RESET;
      filled_r     <= '0;
      hits_r       <= '0;
      misses_r     <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.commit;
      if (cfg_we) cfg_frames_r <= cfg_wdata;
      if (cmd.commit) begin
        filled_r <= filled_nxt;
        hits_r   <= hits_nxt;
        misses_r <= misses_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_r    <= in_req.page;
      eos_r     <= in_req.end_of_string;
      hit_r     <= hit;
      fill_r    <= fill;
      sel_r     <= sel;
      ev_page_r <= frame_page_r[victim];
      limit_r   <= rank_r[hit_idx];
      act_r     <= act;
    end
    if (cmd.commit) begin
      for (int i = 0; i < NF; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
      if (!hit_r) frame_page_r[sel_r] <= page_r;
      out_res_r.hit           <= hit_r;
      out_res_r.frame         <= sel_r;
      out_res_r.evicted_valid <= !hit_r && !fill_r;
      out_res_r.evicted_page  <= (!hit_r && !fill_r) ? ev_page_r : '0;
      out_res_r.hit_total     <= hit_cnt;
      out_res_r.miss_total    <= miss_cnt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire
